// ===== rtl/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, codes and helpers of the block bitmap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

  // Fixed widths of the bitmap words and of the interface fields
  localparam int WORD_BITS     = 64;
  localparam int BIT_W         = 6;
  localparam int BITS_PER_BYTE = 8;
  localparam int DATA_W        = 32;
  localparam int NUM_W         = 15;
  localparam int STATUS_W      = 2;
  localparam int CFG_AW        = 2;
  localparam int SECS_CFG_W    = 4;

  localparam logic [SECS_CFG_W-1:0] BMAP_SECS_RESET = 4'd8;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE   = 2'd0,
    STATUS_FULL   = 2'd1,
    STATUS_REJECT = 2'd2
  } status_t;

  // Configuration register indexes
  typedef enum logic [CFG_AW-1:0] {
    CFG_DATA_START = 2'd0,
    CFG_PART_START = 2'd1,
    CFG_PART_COUNT = 2'd2,
    CFG_BMAP_SECS  = 2'd3
  } cfg_addr_t;

  // Request kinds carried on the input tuser
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Sequencer states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC_SETUP,
    S_SCAN,
    S_ALLOC_IDX,
    S_ALLOC_END,
    S_ALLOC_EVAL,
    S_FREE_SUB,
    S_FREE_DIV,
    S_FREE_CHK,
    S_FREE_EVAL,
    S_FREE_WRITE,
    S_DONE
  } state_t;

  // Position of the lowest clear bit of a word, by halving the search window
  function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_BITS-1:0] word);
    logic [WORD_BITS-1:0] free_bits;
    logic [BIT_W-1:0]     pos;
    free_bits = ~word;
    pos       = '0;
    for (int lvl = BIT_W - 1; lvl >= 0; lvl--) begin
      if ((free_bits & ((64'd1 << (1 << lvl)) - 64'd1)) == '0) begin
        free_bits = free_bits >> (1 << lvl);
        pos[lvl]  = 1'b1;
      end
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bba_map_mem.sv =====
// ----------------------------------------------------------------------------
// bba_map_mem
// Used-block bitmap storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_map_mem #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [AW-1:0]                 waddr,
  input  wire logic [bba_pkg::WORD_BITS-1:0] wdata,
  input  wire logic [AW-1:0]                 raddr,
  output logic      [bba_pkg::WORD_BITS-1:0] rdata
);

  logic [bba_pkg::WORD_BITS-1:0] mem [DEPTH];

  // Write one word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read one word, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/bba_div.sv =====
// ----------------------------------------------------------------------------
// bba_div
// Division by a fixed divisor through one multiply by its reciprocal.
// Dividends at or above DIVISOR * QMAX return QMAX; done rises together with the
// registered product, after the operand is captured on start.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_div #(
  parameter int DIVISOR = 1,
  parameter int QMAX    = 32768
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [bba_pkg::DATA_W-1:0] dividend,
  output logic                            done,
  output logic      [bba_pkg::DATA_W-1:0] quotient
);

  localparam int     DW    = bba_pkg::DATA_W;
  localparam longint LIMIT = longint'(DIVISOR) * longint'(QMAX);
  localparam int     XW    = $clog2(LIMIT);
  localparam int     SH    = XW + $clog2(DIVISOR);
  localparam longint RECIP = ((longint'(1) << SH) + longint'(DIVISOR) - longint'(1)) /
                             longint'(DIVISOR);
  localparam int     MW    = XW + 2;
  localparam int     PW    = XW + MW;

  logic          busy;
  logic          over;
  logic [XW-1:0] x;
  logic [PW-1:0] prod;

  // Step from operand capture to the product
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= start;
      done <= busy;
    end
  end

  // Capture the operand and its range, then multiply by the reciprocal
  always_ff @(posedge clk) begin
    if (start) begin
      over <= (64'(dividend) >= 64'(LIMIT));
      x    <= dividend[XW-1:0];
    end
    if (busy) begin
      prod <= PW'(x) * PW'(RECIP);
    end
  end

  assign quotient = over ? DW'(QMAX) : DW'(prod >> SH);

endmodule

`default_nettype wire

// ===== rtl/block_bitmap_allocator.sv =====
// ----------------------------------------------------------------------------
// block_bitmap_allocator
// Disk block allocator over a used-block bitmap held in a word memory.
// ----------------------------------------------------------------------------
// Allocate: a setup state, then one bitmap word per cycle up to the first word with a
//   clear bit, then index, end and eval states place it; disk full scans every word.
// Free: subtract, divide (reciprocal multiply), check, evaluate, write; below data rejects.
// One request in flight at a time; the result is held in the output register.
// Reset: a clearing pass writes every bitmap word to zero, one word a cycle,
//   with s_tready low until it ends.
// ----------------------------------------------------------------------------
`default_nettype none

module block_bitmap_allocator #(
  parameter int SECTOR_BYTES       = 512,
  parameter int SECTORS_PER_BLOCK  = 1,
  parameter int MAX_BITMAP_SECTORS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration write port
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [31:0] cfg_wdata,
  // Request stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] start_sector
  input  wire logic [0:0]  s_tuser,   // [0] req_type
  // Result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // [31:0] block_start_sector, [46:32] block_number
  output logic [1:0]       m_tuser    // [1:0] status
);

  localparam int WB              = bba_pkg::WORD_BITS;
  localparam int BW              = bba_pkg::BIT_W;
  localparam int NUM_W           = bba_pkg::NUM_W;
  localparam int BITS_PER_SECTOR = SECTOR_BYTES * bba_pkg::BITS_PER_BYTE;
  localparam int MAP_BITS        = MAX_BITMAP_SECTORS * BITS_PER_SECTOR;
  localparam int MAP_WORDS       = (MAP_BITS + WB - 1) / WB;
  localparam int WADDR_W         = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int WCNT_W          = $clog2(MAP_WORDS + 1);
  localparam int LIM_W           = $clog2(MAP_BITS + 1);
  localparam int IDX_W           = WADDR_W + BW;
  localparam int SECS_W          = $clog2(MAX_BITMAP_SECTORS + 1);
  localparam int SPB_W           = $clog2(SECTORS_PER_BLOCK + 1);
  localparam int FP_W            = 33 + SPB_W;
  localparam int E_W             = 34;

  // Configuration registers
  logic [31:0]                       data_start;
  logic [31:0]                       part_start;
  logic [31:0]                       part_count;
  logic [bba_pkg::SECS_CFG_W-1:0]    bmap_secs;

  // Derived search bounds
  logic [SECS_W-1:0]  secs_c;
  logic [LIM_W-1:0]   limit;
  logic [WCNT_W-1:0]  limit_words;
  logic [32:0]        max_sec;

  // Sequencer
  bba_pkg::state_t state, state_next;

  // Working registers
  logic [WADDR_W-1:0] clr_addr;
  logic [WCNT_W-1:0]  scan_addr;
  logic [WADDR_W-1:0] chk_addr;
  logic               chk_valid;
  logic [WB-1:0]      fword;
  logic [WADDR_W-1:0] fwaddr;
  logic [IDX_W-1:0]   idx;
  logic               in_limit;
  logic [E_W-1:0]     end_sec;
  logic [31:0]        start_sec;
  logic [31:0]        sec;
  logic [FP_W-1:0]    fprod;

  // Result staging
  bba_pkg::status_t   res_status;
  logic [31:0]        res_start;
  logic [NUM_W-1:0]   res_num;

  // Memory and divider hookup
  logic               mem_we;
  logic [WADDR_W-1:0] mem_waddr;
  logic [WB-1:0]      mem_wdata;
  logic [WADDR_W-1:0] mem_raddr;
  logic [WB-1:0]      mem_rdata;
  logic               div_start;
  logic               div_done;
  logic [31:0]        quotient;

  // Decisions
  logic               issue_ok;
  logic               found;
  logic               scan_end;
  logic               below;
  logic               full_c;
  logic               reject_c;
  logic               out_load;
  logic [E_W-1:0]     prod_c;

  // ---------------------------------------------------------------------------
  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      data_start <= '0;
      part_start <= '0;
      part_count <= '0;
      bmap_secs  <= bba_pkg::BMAP_SECS_RESET;
    end else if (cfg_we) begin
      case (bba_pkg::cfg_addr_t'(cfg_addr))
        bba_pkg::CFG_DATA_START: data_start <= cfg_wdata;
        bba_pkg::CFG_PART_START: part_start <= cfg_wdata;
        bba_pkg::CFG_PART_COUNT: part_count <= cfg_wdata;
        bba_pkg::CFG_BMAP_SECS:  bmap_secs  <= cfg_wdata[bba_pkg::SECS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the sector count, then register the bit and word limits
  always_comb begin
    if (32'(bmap_secs) > 32'(MAX_BITMAP_SECTORS)) begin
      secs_c = SECS_W'(MAX_BITMAP_SECTORS);
    end else begin
      secs_c = SECS_W'(bmap_secs);
    end
  end

  always_ff @(posedge clk) begin
    limit       <= LIM_W'(32'(secs_c) * 32'(BITS_PER_SECTOR));
    limit_words <= WCNT_W'((32'(limit) + 32'(WB - 1)) >> BW);
    max_sec     <= 33'(part_start) + 33'(part_count);
  end

  // ---------------------------------------------------------------------------
  // Bitmap memory and divider
  bba_map_mem #(
    .DEPTH (MAP_WORDS),
    .AW    (WADDR_W)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bba_div #(
    .DIVISOR (SECTORS_PER_BLOCK),
    .QMAX    (MAP_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sec - data_start),
    .done     (div_done),
    .quotient (quotient)
  );

  // ---------------------------------------------------------------------------
  // Decision terms
  always_comb begin
    issue_ok = (scan_addr < limit_words);
    found    = chk_valid && (mem_rdata != '1);
    scan_end = !chk_valid && !issue_ok;
    below    = (sec < data_start);
    full_c   = !in_limit || (end_sec > E_W'(max_sec)) || (end_sec > E_W'(34'h1_0000_0000));
    reject_c = (quotient == '0) || (fprod > FP_W'(part_count)) ||
               (quotient >= 32'(MAP_BITS));
    prod_c   = E_W'(idx) * E_W'(SECTORS_PER_BLOCK);
  end

  // ---------------------------------------------------------------------------
  // Next state
  always_comb begin
    state_next = state;
    case (state)
      bba_pkg::S_CLEAR: begin
        if (clr_addr == WADDR_W'(MAP_WORDS - 1)) begin
          state_next = bba_pkg::S_IDLE;
        end
      end
      bba_pkg::S_IDLE: begin
        if (s_tvalid) begin
          state_next = (s_tuser[0] == bba_pkg::REQ_FREE) ? bba_pkg::S_FREE_SUB
                                                          : bba_pkg::S_ALLOC_SETUP;
        end
      end
      bba_pkg::S_ALLOC_SETUP: state_next = bba_pkg::S_SCAN;
      bba_pkg::S_SCAN: begin
        if (found) begin
          state_next = bba_pkg::S_ALLOC_IDX;
        end else if (scan_end) begin
          state_next = bba_pkg::S_DONE;
        end
      end
      bba_pkg::S_ALLOC_IDX:  state_next = bba_pkg::S_ALLOC_END;
      bba_pkg::S_ALLOC_END:  state_next = bba_pkg::S_ALLOC_EVAL;
      bba_pkg::S_ALLOC_EVAL: state_next = bba_pkg::S_DONE;
      bba_pkg::S_FREE_SUB: begin
        state_next = below ? bba_pkg::S_DONE : bba_pkg::S_FREE_DIV;
      end
      bba_pkg::S_FREE_DIV: begin
        if (div_done) begin
          state_next = bba_pkg::S_FREE_CHK;
        end
      end
      bba_pkg::S_FREE_CHK:  state_next = bba_pkg::S_FREE_EVAL;
      bba_pkg::S_FREE_EVAL: begin
        state_next = reject_c ? bba_pkg::S_DONE : bba_pkg::S_FREE_WRITE;
      end
      bba_pkg::S_FREE_WRITE: state_next = bba_pkg::S_DONE;
      bba_pkg::S_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = bba_pkg::S_IDLE;
        end
      end
      default: state_next = bba_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer outputs
  always_comb begin
    s_tready  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = idx[IDX_W-1:BW];
    mem_wdata = fword | (64'd1 << idx[BW-1:0]);
    mem_raddr = scan_addr[WADDR_W-1:0];
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state)
      bba_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      bba_pkg::S_IDLE: s_tready = 1'b1;
      bba_pkg::S_ALLOC_EVAL: mem_we = !full_c;
      bba_pkg::S_FREE_SUB:   div_start = !below;
      bba_pkg::S_FREE_EVAL:  mem_raddr = quotient[IDX_W-1:BW];
      bba_pkg::S_FREE_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = quotient[IDX_W-1:BW];
        mem_wdata = mem_rdata & ~(64'd1 << quotient[BW-1:0]);
      end
      bba_pkg::S_DONE: out_load = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bba_pkg::S_CLEAR;
      clr_addr  <= '0;
      chk_valid <= 1'b0;
      scan_addr <= '0;
    end else begin
      state <= state_next;
      if (state == bba_pkg::S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == bba_pkg::S_ALLOC_SETUP) begin
        scan_addr <= '0;
        chk_valid <= 1'b0;
      end else if (state == bba_pkg::S_SCAN) begin
        chk_valid <= issue_ok;
        if (issue_ok) begin
          scan_addr <= scan_addr + 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      bba_pkg::S_IDLE: sec <= s_tdata;
      bba_pkg::S_SCAN: begin
        chk_addr <= scan_addr[WADDR_W-1:0];
        if (found) begin
          fword  <= mem_rdata;
          fwaddr <= chk_addr;
        end else if (scan_end) begin
          res_status <= bba_pkg::STATUS_FULL;
          res_start  <= '0;
          res_num    <= '0;
        end
      end
      bba_pkg::S_ALLOC_IDX: idx <= {fwaddr, bba_pkg::first_zero(fword)};
      bba_pkg::S_ALLOC_END: begin
        in_limit  <= (32'(idx) < 32'(limit));
        end_sec   <= prod_c + E_W'(SECTORS_PER_BLOCK) + E_W'(data_start);
        start_sec <= 32'(prod_c + E_W'(data_start));
      end
      bba_pkg::S_ALLOC_EVAL: begin
        if (full_c) begin
          res_status <= bba_pkg::STATUS_FULL;
          res_start  <= '0;
          res_num    <= '0;
        end else begin
          res_status <= bba_pkg::STATUS_DONE;
          res_start  <= start_sec;
          res_num    <= NUM_W'(idx);
        end
      end
      bba_pkg::S_FREE_SUB: begin
        if (below) begin
          res_status <= bba_pkg::STATUS_REJECT;
          res_start  <= '0;
          res_num    <= '0;
        end
      end
      bba_pkg::S_FREE_CHK: begin
        fprod <= (FP_W'(quotient) + FP_W'(1)) * FP_W'(SECTORS_PER_BLOCK);
      end
      bba_pkg::S_FREE_EVAL: begin
        if (reject_c) begin
          res_status <= bba_pkg::STATUS_REJECT;
          res_start  <= '0;
          res_num    <= '0;
        end
      end
      bba_pkg::S_FREE_WRITE: begin
        res_status <= bba_pkg::STATUS_DONE;
        res_start  <= '0;
        res_num    <= quotient[NUM_W-1:0];
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output register: load a finished word, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {1'b0, res_num, res_start};
      m_tuser <= res_status;
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while another is in work");

  a_div_done_in_free: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == bba_pkg::S_FREE_DIV)
    else $error("divider finished outside a free request");

  a_scan_in_bounds: assert property (@(posedge clk) disable iff (rst)
    state == bba_pkg::S_SCAN && chk_valid |-> 32'(chk_addr) < 32'(limit_words))
    else $error("bitmap scan past the configured words");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser == bba_pkg::STATUS_DONE || m_tuser == bba_pkg::STATUS_FULL ||
                 m_tuser == bba_pkg::STATUS_REJECT)
    else $error("result carries an undefined status");

endmodule

`default_nettype wire
